FILE: hdl/sjis_euc_stream_converter_core_macros.svh
// Assertion macros shared by the converter RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef SJIS_EUC_STREAM_CONVERTER_CORE_MACROS_SVH
`define SJIS_EUC_STREAM_CONVERTER_CORE_MACROS_SVH

// Property checked on every rising clock edge outside reset
`define SJIS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never hold outside reset
`define SJIS_NEVER(lbl, cond, msg) \
	`SJIS_ASSERT(lbl, !(cond), msg)

`endif

FILE: hdl/sjis_pkg.sv
// Shared types, codes and constants of the Shift-JIS / EUC-JP converter.
// No dependencies; used by sjis_conv, sjis_outq and the top-level core.
package sjis_pkg;

	// direction register codes
	localparam logic [1:0] DIR_PASS = 2'd0;
	localparam logic [1:0] DIR_S2E  = 2'd1;
	localparam logic [1:0] DIR_E2S  = 2'd2;

	// detection state codes
	localparam logic [1:0] DET_NONE  = 2'd0;
	localparam logic [1:0] DET_EUC   = 2'd1;
	localparam logic [1:0] DET_SJIS  = 2'd2;
	localparam logic [1:0] DET_MIXED = 2'd3;

	// Shift-JIS to EUC-JP offsets
	localparam logic [7:0] S2E_TRAIL_SPLIT = 8'h9f;
	localparam logic [7:0] S2E_LEAD_SPLIT  = 8'he0;
	localparam logic [7:0] S2E_HI_EVEN     = 8'he0;
	localparam logic [7:0] S2E_LO_EVEN     = 8'h60;
	localparam logic [7:0] S2E_HI_ODD      = 8'he1;
	localparam logic [7:0] S2E_LO_ODD      = 8'h61;
	localparam logic [7:0] S2E_TRAIL_GAP   = 8'h7f;
	localparam logic [7:0] S2E_TRAIL_OFS   = 8'h60;

	// EUC-JP to Shift-JIS offsets
	localparam logic [7:0] E2S_LEAD_SPLIT  = 8'hdf;
	localparam logic [7:0] E2S_LO_ODD      = 8'h31;
	localparam logic [7:0] E2S_HI_ODD      = 8'h71;
	localparam logic [7:0] E2S_LO_EVEN     = 8'h30;
	localparam logic [7:0] E2S_HI_EVEN     = 8'h70;
	localparam logic [7:0] E2S_TRAIL_SPLIT = 8'he0;
	localparam logic [7:0] E2S_TRAIL_OFS   = 8'h60;
	localparam logic [7:0] EUC_ROW_LOW     = 8'ha1;

	// depth of the result queue
	localparam int QUEUE_DEPTH = 4;

	// one result beat
	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       string_end;
		logic [1:0] detected_code;
	} beat_t;

	// queue write request, wr1 only together with wr0
	typedef struct packed {
		logic  wr0;
		logic  wr1;
		beat_t beat0;
		beat_t beat1;
	} q_wr_t;

	// reported code for a detection state
	function automatic logic [1:0] code_of(input logic [1:0] det);
		return (det == DET_MIXED) ? DET_NONE : det;
	endfunction

endpackage

FILE: hdl/sjis_in_if.sv
// Input byte channel: valid/ready handshake with byte and end-of-string flag.
// No dependencies.
interface sjis_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       string_last;

	modport source (output valid, output in_byte, output string_last, input ready);
	modport sink (input valid, input in_byte, input string_last, output ready);
endinterface

FILE: hdl/sjis_out_if.sv
// Result byte channel: valid/ready handshake with byte, flags and detection code.
// No dependencies.
interface sjis_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       string_end;
	logic [1:0] detected_code;

	modport source (output valid, output out_byte, output run_last,
		output string_end, output detected_code, input ready);
	modport sink (input valid, input out_byte, input run_last,
		input string_end, input detected_code, output ready);
endinterface

FILE: hdl/sjis_conv.sv
// Pair converter and shape classifier, purely combinational.
// Depends on sjis_pkg.
module sjis_conv import sjis_pkg::*; (
	input  logic [1:0] direction,
	input  logic [7:0] lead,
	input  logic [7:0] trail,
	input  logic [1:0] det_cur,
	output logic [7:0] conv_lead,
	output logic [7:0] conv_trail,
	output logic [1:0] det_nxt
);

	logic [7:0] lead_x2;
	logic [7:0] lead_div2;
	logic       is_euc;
	logic       is_sjis;

	assign lead_x2   = {lead[6:0], 1'b0};
	assign lead_div2 = {1'b0, lead[7:1]};

	// byte pair conversion, all modulo 256
	always_comb begin
		conv_lead  = lead;
		conv_trail = trail;
		case (direction)
			DIR_S2E: begin
				if (trail >= S2E_TRAIL_SPLIT) begin
					conv_lead  = lead_x2 - ((lead >= S2E_LEAD_SPLIT) ? S2E_HI_EVEN : S2E_LO_EVEN);
					conv_trail = trail + 8'd2;
				end else begin
					conv_lead  = lead_x2 - ((lead >= S2E_LEAD_SPLIT) ? S2E_HI_ODD : S2E_LO_ODD);
					conv_trail = trail + S2E_TRAIL_OFS + {7'd0, (trail < S2E_TRAIL_GAP)};
				end
			end
			DIR_E2S: begin
				if (lead[0]) begin
					conv_lead  = lead_div2 + ((lead < E2S_LEAD_SPLIT) ? E2S_LO_ODD : E2S_HI_ODD);
					conv_trail = trail - (E2S_TRAIL_OFS + {7'd0, (trail < E2S_TRAIL_SPLIT)});
				end else begin
					conv_lead  = lead_div2 + ((lead < E2S_LEAD_SPLIT) ? E2S_LO_EVEN : E2S_HI_EVEN);
					conv_trail = trail - 8'd2;
				end
			end
			default: begin
				conv_lead  = lead;
				conv_trail = trail;
			end
		endcase
	end

	// shape of the pair
	always_comb begin
		is_euc  = (lead inside {[EUC_ROW_LOW:8'hdf], [8'hfd:8'hfe]}) &&
			(trail inside {[EUC_ROW_LOW:8'hfe]});
		is_sjis = ((lead inside {[8'h81:8'h9f]}) &&
			(trail inside {[8'h40:8'h7e], [8'h80:8'hfc]})) ||
			((lead inside {[8'he0:8'hfc]}) && (trail inside {[8'h40:8'h7e]}));
	end

	// sticky detection; a second, different shape makes it mixed
	always_comb begin
		det_nxt = det_cur;
		if (is_euc) begin
			det_nxt = (det_cur == DET_NONE) ? DET_EUC :
				((det_cur != DET_EUC) ? DET_MIXED : det_cur);
		end else if (is_sjis) begin
			det_nxt = (det_cur == DET_NONE) ? DET_SJIS :
				((det_cur != DET_SJIS) ? DET_MIXED : det_cur);
		end
	end

endmodule

FILE: hdl/sjis_outq.sv
// Result queue: takes up to two beats a cycle, hands out one beat a cycle while the receiver is ready.
// Depends on sjis_pkg, sjis_out_if and the assertion macros.
`include "sjis_euc_stream_converter_core_macros.svh"
module sjis_outq import sjis_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  q_wr_t             wr,
	output logic              room,
	sjis_out_if.source        out_chan
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	beat_t          mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic [PW-1:0]  wr_ptr1;
	logic           pop;
	beat_t          head;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign wr_ptr1 = ptr_inc(wr_ptr_q);
	assign pop     = out_chan.valid && out_chan.ready;
	assign room    = (count_q <= CW'(DEPTH - 2));

	// storage
	always_ff @(posedge clk) begin
		if (wr.wr0) begin
			mem_q[wr_ptr_q] <= wr.beat0;
		end
		if (wr.wr1) begin
			mem_q[wr_ptr1] <= wr.beat1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr.wr1) begin
				wr_ptr_q <= ptr_inc(wr_ptr1);
			end else if (wr.wr0) begin
				wr_ptr_q <= wr_ptr1;
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			count_q <= count_q + CW'(wr.wr0) + CW'(wr.wr1) - CW'(pop);
		end
	end

	// head beat to the port
	assign head                   = mem_q[rd_ptr_q];
	assign out_chan.valid         = (count_q != '0);
	assign out_chan.out_byte      = head.out_byte;
	assign out_chan.run_last      = head.run_last;
	assign out_chan.string_end    = head.string_end;
	assign out_chan.detected_code = head.detected_code;

	`SJIS_NEVER(a_count_bound, count_q > CW'(DEPTH), "queue fill count beyond depth")
	`SJIS_NEVER(a_wr_order, wr.wr1 && !wr.wr0, "second beat written without the first")
	`SJIS_ASSERT(a_two_rise, (wr.wr1 && !pop) |=> (count_q == $past(count_q) + CW'(2)), "pair write lost")

endmodule

FILE: hdl/sjis_euc_stream_converter_core.sv
// Top level of the Shift-JIS / EUC-JP stream converter.
// Depends on sjis_pkg, sjis_in_if, sjis_out_if, sjis_conv, sjis_outq and the macros.
//
//  channel   | dir | beat fields                                   | per beat
//  ----------+-----+-----------------------------------------------+-------------------
//  in_chan   | in  | in_byte, string_last                          | one string byte
//  out_chan  | out | out_byte, run_last, string_end, detected_code | one result byte
//  cfg port  | in  | cfg_we, cfg_wdata (direction)                 | one register write
//
// One input beat a cycle; an input beat passes the input register, then the result
// queue, before it shows as output valid. A paired trail writes two beats
// into the queue at once, which drains one beat a cycle while the receiver
// is ready; input stalls only while the queue cannot take two more. Reset
// clears direction, the lead byte state, detection and the queue; no clearing pass.
`include "sjis_euc_stream_converter_core_macros.svh"
module sjis_euc_stream_converter_core import sjis_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	sjis_in_if.sink     in_chan,
	sjis_out_if.source  out_chan
);

	logic       v_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic [1:0] direction_q;
	logic       lead_pending_q;
	logic [7:0] lead_byte_q;
	logic [1:0] detect_q;
	logic       room;
	logic       adv;
	logic       pair;
	logic       lone;
	logic [7:0] conv_a;
	logic [7:0] conv_b;
	logic [7:0] oa;
	logic [7:0] ob;
	logic [1:0] det_nxt;
	logic [1:0] code_now;
	logic [1:0] code_pair;
	q_wr_t      wr;

	assign adv           = v_s1 && room;
	assign in_chan.ready = !v_s1 || adv;

	// direction register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DIR_PASS;
		end else if (cfg_we) begin
			direction_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_chan.ready) begin
			v_s1 <= in_chan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_chan.ready && in_chan.valid) begin
			byte_s1 <= in_chan.in_byte;
			last_s1 <= in_chan.string_last;
		end
	end

	// pair selection: held lead with this byte, or a closing lead with zero
	assign pair   = lead_pending_q;
	assign lone   = !lead_pending_q && byte_s1[7];
	assign conv_a = pair ? lead_byte_q : byte_s1;
	assign conv_b = pair ? byte_s1 : 8'h00;

	sjis_conv u_conv (
		.direction  (direction_q),
		.lead       (conv_a),
		.trail      (conv_b),
		.det_cur    (detect_q),
		.conv_lead  (oa),
		.conv_trail (ob),
		.det_nxt    (det_nxt)
	);

	assign code_now  = code_of(detect_q);
	assign code_pair = code_of(det_nxt);

	// result beats into the queue
	always_comb begin
		wr.wr0 = adv && !(lone && !last_s1);
		wr.wr1 = adv && pair;
		wr.beat1 = '{out_byte: ob, run_last: 1'b1, string_end: last_s1,
			detected_code: code_pair};
		if (pair) begin
			wr.beat0 = '{out_byte: oa, run_last: 1'b0, string_end: 1'b0,
				detected_code: code_pair};
		end else if (lone) begin
			wr.beat0 = '{out_byte: oa, run_last: 1'b1, string_end: 1'b1,
				detected_code: code_now};
		end else begin
			wr.beat0 = '{out_byte: byte_s1, run_last: 1'b1, string_end: last_s1,
				detected_code: code_now};
		end
	end

	// lead byte and detection state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_pending_q <= 1'b0;
			lead_byte_q    <= 8'h00;
			detect_q       <= DET_NONE;
		end else if (adv) begin
			if (last_s1) begin
				lead_pending_q <= 1'b0;
				detect_q       <= DET_NONE;
			end else if (pair) begin
				lead_pending_q <= 1'b0;
				detect_q       <= det_nxt;
			end else if (lone) begin
				lead_pending_q <= 1'b1;
				lead_byte_q    <= byte_s1;
			end
		end
	end

	sjis_outq #(
		.DEPTH (QDEPTH)
	) u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.room     (room),
		.out_chan (out_chan)
	);

	`SJIS_ASSERT(a_end_clears, (adv && last_s1) |=> (!lead_pending_q && detect_q == DET_NONE), "string end left state behind")
	`SJIS_ASSERT(a_pair_two, (adv && lead_pending_q) |-> wr.wr1, "pair gave fewer than two beats")
	`SJIS_NEVER(a_wr_no_adv, wr.wr0 && !adv, "queue written without an advancing beat")

endmodule

FILE: dv/sjis_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the Shift-JIS / EUC-JP stream converter: tracks lead byte, detection
// and direction from the watched beats, and compares every output beat in order.
// Depends on sjis_pkg, sjis_in_if and sjis_out_if.
module sjis_result_checker import sjis_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	sjis_in_if         in_mon,
	sjis_out_if        out_mon,
	output int         fail_count,
	output int         owed
);

	// result beats still to come, oldest first
	beat_t      owed_beats[$];

	// own copy of register and stream state
	logic [1:0] dir_reg;
	logic       lead_held;
	logic [7:0] lead_val;
	logic [1:0] det_seen;

	// Shift-JIS pair to EUC-JP, {lead, trail}
	function automatic logic [15:0] sjis_to_euc_pair(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] x;
		logic [7:0] y;
		x = {a[6:0], 1'b0};
		if (b >= 8'h9f) begin
			x = x - ((a >= 8'he0) ? 8'he0 : 8'h60);
			y = b + 8'h02;
		end else begin
			x = x - ((a >= 8'he0) ? 8'he1 : 8'h61);
			y = b + 8'h60 + ((b < 8'h7f) ? 8'h01 : 8'h00);
		end
		return {x, y};
	endfunction

	// EUC-JP pair to Shift-JIS, {lead, trail}
	function automatic logic [15:0] euc_to_sjis_pair(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] x;
		logic [7:0] y;
		if (a[0]) begin
			x = {1'b0, a[7:1]} + ((a < 8'hdf) ? 8'h31 : 8'h71);
			y = b - (8'h60 + ((b < 8'he0) ? 8'h01 : 8'h00));
		end else begin
			x = {1'b0, a[7:1]} + ((a < 8'hdf) ? 8'h30 : 8'h70);
			y = b - 8'h02;
		end
		return {x, y};
	endfunction

	// pair as the direction register wants it; the spare code passes through
	function automatic logic [15:0] recode_pair(input logic [7:0] a, input logic [7:0] b);
		case (dir_reg)
			DIR_S2E: return sjis_to_euc_pair(a, b);
			DIR_E2S: return euc_to_sjis_pair(a, b);
			default: return {a, b};
		endcase
	endfunction

	// shape of a pair: EUC first, then Shift-JIS, else none
	function automatic logic [1:0] pair_shape(input logic [7:0] a, input logic [7:0] b);
		if (((a >= 8'ha1 && a <= 8'hdf) || (a >= 8'hfd && a <= 8'hfe)) &&
				(b >= 8'ha1 && b <= 8'hfe))
			return DET_EUC;
		if ((a >= 8'h81 && a <= 8'h9f) &&
				((b >= 8'h40 && b <= 8'h7e) || (b >= 8'h80 && b <= 8'hfc)))
			return DET_SJIS;
		if ((a >= 8'he0 && a <= 8'hfc) && (b >= 8'h40 && b <= 8'h7e))
			return DET_SJIS;
		return DET_NONE;
	endfunction

	// result beat tagged with the code reported for the current detection
	function automatic beat_t tag_beat(input logic [7:0] v, input logic rl, input logic se);
		beat_t t;
		t.out_byte      = v;
		t.run_last      = rl;
		t.string_end    = se;
		t.detected_code = (det_seen == DET_MIXED) ? DET_NONE : det_seen;
		return t;
	endfunction

	// work out the beats one accepted input byte causes
	function automatic void expect_from_byte(input logic [7:0] b, input logic last);
		logic [15:0] pr;
		logic [1:0]  sh;
		if (lead_held) begin
			sh = pair_shape(lead_val, b);
			if (sh != DET_NONE) begin
				if (det_seen == DET_NONE)
					det_seen = sh;
				else if (det_seen != sh)
					det_seen = DET_MIXED;
			end
			pr = recode_pair(lead_val, b);
			lead_held = 1'b0;
			owed_beats.push_back(tag_beat(pr[15:8], 1'b0, 1'b0));
			owed_beats.push_back(tag_beat(pr[7:0], 1'b1, last));
		end else if (b[7]) begin
			if (last) begin
				// dangling lead: zero trail, lead half only
				pr = recode_pair(b, 8'h00);
				owed_beats.push_back(tag_beat(pr[15:8], 1'b1, 1'b1));
			end else begin
				lead_val  = b;
				lead_held = 1'b1;
			end
		end else begin
			owed_beats.push_back(tag_beat(b, 1'b1, last));
		end
		if (last) begin
			lead_held = 1'b0;
			det_seen  = DET_NONE;
		end
	endfunction

	// compare output beats, then predict from input beats, then take register writes
	always @(posedge clk or negedge arst_n) begin
		beat_t want;
		if (!arst_n) begin
			dir_reg    = DIR_PASS;
			lead_held  = 1'b0;
			lead_val   = 8'h00;
			det_seen   = DET_NONE;
			owed_beats.delete();
			fail_count = 0;
			owed      <= 0;
		end else begin
			if (out_mon.valid && out_mon.ready) begin
				if (owed_beats.size() == 0) begin
					$error("result beat with none owed: out_byte %h", out_mon.out_byte);
					fail_count++;
				end else begin
					want = owed_beats.pop_front();
					if (out_mon.out_byte !== want.out_byte) begin
						$error("out_byte: expected %h, got %h", want.out_byte, out_mon.out_byte);
						fail_count++;
					end
					if (out_mon.run_last !== want.run_last) begin
						$error("run_last: expected %b, got %b", want.run_last, out_mon.run_last);
						fail_count++;
					end
					if (out_mon.string_end !== want.string_end) begin
						$error("string_end: expected %b, got %b", want.string_end,
							out_mon.string_end);
						fail_count++;
					end
					if (out_mon.detected_code !== want.detected_code) begin
						$error("detected_code: expected %0d, got %0d", want.detected_code,
							out_mon.detected_code);
						fail_count++;
					end
				end
			end
			if (in_mon.valid && in_mon.ready)
				expect_from_byte(in_mon.in_byte, in_mon.string_last);
			if (cfg_we)
				dir_reg = cfg_wdata;
			owed <= owed_beats.size();
		end
	end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// Top of the converter testbench: clock, reset, byte strings in bursts, receiver stalls,
// direction changes and the verdict. Depends on sjis_pkg, the channel interfaces,
// sjis_euc_stream_converter_core and sjis_result_checker.
module tb_top;
	import sjis_pkg::*;

	// spare direction code, behaves as pass through
	localparam logic [1:0] DIR_SPARE = 2'd3;
	// cycles the block needs after its last owed beat
	localparam int SETTLE = 4;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_wdata;
	int         fails;
	int         owed;
	int         burst_left = 0;

	// receiver stall pattern state
	int         rx_mode = 0;
	int         rx_left = 0;
	int         rx_stall = 0;

	// direction per random phase, extremes and the spare code included
	logic [1:0] phase_dir [8] = '{DIR_S2E, DIR_E2S, DIR_PASS, DIR_SPARE,
		DIR_E2S, DIR_S2E, DIR_SPARE, DIR_PASS};

	sjis_in_if  in_chan ();
	sjis_out_if out_chan ();

	sjis_euc_stream_converter_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_chan   (in_chan),
		.out_chan  (out_chan)
	);

	sjis_result_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_mon     (in_chan),
		.out_mon    (out_chan),
		.fail_count (fails),
		.owed       (owed)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: modes of always ready, coin flip, mostly ready, and stall runs
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(0, 3);
			rx_left <= $urandom_range(20, 200);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			0: out_chan.ready <= 1'b1;
			1: out_chan.ready <= 1'($urandom_range(0, 1));
			2: out_chan.ready <= ($urandom_range(0, 4) != 0);
			default: begin
				if (rx_stall != 0) begin
					out_chan.ready <= 1'b0;
					rx_stall <= rx_stall - 1;
				end else begin
					out_chan.ready <= 1'b1;
					if ($urandom_range(0, 3) == 0)
						rx_stall <= $urandom_range(1, 12);
				end
			end
		endcase
	end

	// run cut short if the block hangs
	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// one input beat, with a random gap whenever a burst runs out
	task automatic put_byte(input logic [7:0] b, input logic l);
		int  gap;
		logic took;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 20) : $urandom_range(0, 3);
			if (gap != 0) begin
				in_chan.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 32);
		end
		in_chan.valid       <= 1'b1;
		in_chan.in_byte     <= b;
		in_chan.string_last <= l;
		// ready is settled by the falling edge
		do begin
			@(negedge clk);
			took = in_chan.ready;
			@(posedge clk);
		end while (!took);
		burst_left--;
	endtask

	// hold the sender until every owed beat has come out
	task automatic wait_drained();
		in_chan.valid <= 1'b0;
		do @(negedge clk); while (owed != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// direction write, only with the block idle
	task automatic set_dir(input logic [1:0] d);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= d;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// one random string: mostly well-formed text of one encoding, some noise
	task automatic send_string(output int n);
		logic [7:0] txt[$];
		logic [7:0] lead;
		int         len, style, k;
		logic       euc_main, pick_euc;
		len      = $urandom_range(1, 16);
		style    = $urandom_range(0, 9);
		euc_main = 1'($urandom_range(0, 1));
		while (txt.size() < len) begin
			if (style >= 7) begin
				txt.push_back(8'($urandom_range(0, 255)));
			end else begin
				k = $urandom_range(0, 7);
				pick_euc = euc_main ^ (k == 7);
				if (k < 3) begin
					txt.push_back(8'($urandom_range(0, 127)));
				end else if (pick_euc) begin
					if ($urandom_range(0, 15) == 0)
						txt.push_back(8'($urandom_range(8'hfd, 8'hfe)));
					else
						txt.push_back(8'($urandom_range(8'ha1, 8'hdf)));
					txt.push_back(8'($urandom_range(8'ha1, 8'hfe)));
				end else begin
					if ($urandom_range(0, 1) == 0)
						lead = 8'($urandom_range(8'h81, 8'h9f));
					else
						lead = 8'($urandom_range(8'he0, 8'hfc));
					txt.push_back(lead);
					if (lead < 8'he0 && $urandom_range(0, 1) == 0)
						txt.push_back(8'($urandom_range(8'h80, 8'hfc)));
					else
						txt.push_back(8'($urandom_range(8'h40, 8'h7e)));
				end
			end
		end
		// now and then a lead byte left dangling at the end
		if (style < 7 && $urandom_range(0, 5) == 0)
			txt.push_back(8'($urandom_range(128, 255)));
		foreach (txt[i])
			put_byte(txt[i], i == txt.size() - 1);
		n = txt.size();
	endtask

	// stimulus and verdict
	initial begin
		int sent, n, strings;
		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_wdata           <= DIR_PASS;
		in_chan.valid       <= 1'b0;
		in_chan.in_byte     <= 8'h00;
		in_chan.string_last <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Shift-JIS side: ASCII extremes, pairs across the splits, zero trail, lone lead
		set_dir(DIR_S2E);
		put_byte(8'h00, 1'b0);
		put_byte(8'h7f, 1'b1);
		put_byte(8'h81, 1'b0);
		put_byte(8'h40, 1'b0);
		put_byte(8'h9f, 1'b0);
		put_byte(8'hfc, 1'b0);
		put_byte(8'he0, 1'b0);
		put_byte(8'h9e, 1'b0);
		put_byte(8'hfc, 1'b0);
		put_byte(8'h9f, 1'b1);
		put_byte(8'h88, 1'b0);
		put_byte(8'h00, 1'b1);
		put_byte(8'hff, 1'b1);

		// EUC side: corner pairs, a mixed string, lowest lone lead
		set_dir(DIR_E2S);
		put_byte(8'ha1, 1'b0);
		put_byte(8'ha1, 1'b0);
		put_byte(8'hdf, 1'b0);
		put_byte(8'he0, 1'b0);
		put_byte(8'hfe, 1'b0);
		put_byte(8'hfe, 1'b1);
		put_byte(8'ha1, 1'b0);
		put_byte(8'ha1, 1'b0);
		put_byte(8'h81, 1'b0);
		put_byte(8'h40, 1'b1);
		put_byte(8'h80, 1'b1);

		// random phases, one direction each, with one drain pause inside each
		foreach (phase_dir[p]) begin
			set_dir(phase_dir[p]);
			sent    = 0;
			strings = 0;
			while (sent < 190) begin
				send_string(n);
				sent += n;
				strings++;
				if (strings == 6)
					wait_drained();
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
